@@ design/pcg32_stream_with_bounded_draw_assert.svh @@
// assertion macros for the pcg32 stream block
`ifndef PCG32_STREAM_WITH_BOUNDED_DRAW_ASSERT_SVH
`define PCG32_STREAM_WITH_BOUNDED_DRAW_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PCG32_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("pcg32 check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define PCG32_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("pcg32 check failed");

`endif

@@ design/pcg32_pkg.sv @@
// shared types, constants and the output permutation of the pcg32 stream block
`default_nettype none

package pcg32_pkg;

  localparam logic [63:0] PCG_MUL = 64'd6364136223846793005;
  localparam logic [63:0] PCG_INC = 64'd1442695040888963407;
  localparam int unsigned SHIFT_A = 18;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned ROT_SHIFT = 59;
  localparam logic [3:0] MIX_ROUNDS = 4'd10;
  localparam int unsigned DIV_BITS = 64;
  localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);

  typedef enum logic [1:0] {
    REQ_SEED    = 2'd0,
    REQ_DRAW    = 2'd1,
    REQ_BOUNDED = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HL = 2'd2
  } mul_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_DRAW = 2'd1,
    RES_REM  = 2'd2
  } res_sel_e;

  typedef enum logic {
    DIV_SRC_LIM = 1'b0,
    DIV_SRC_MOD = 1'b1
  } div_src_e;

  typedef struct packed {
    logic     load_in;
    logic     seed_user;
    logic     seed_default;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     adv;
    logic     cap_hi;
    logic     cap_lo;
    logic     div_init;
    div_src_e div_src;
    logic     div_step;
    logic     lim_cap;
    logic     res_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    req_e req_type;
    logic bound_ok;
    logic seeded;
    logic v_lt_limit;
  } sts_t;

  // xsh-rr output of one step, taken from the state before the step
  function automatic logic [31:0] pcg_output(input logic [63:0] s);
    logic [63:0] f;
    logic [31:0] x;
    logic [4:0]  r;
    logic [63:0] xx;
    f  = (s >> SHIFT_A) ^ s;
    x  = 32'(f >> SHIFT_B);
    r  = 5'(s >> ROT_SHIFT);
    xx = {x, x} >> r;
    return xx[31:0];
  endfunction

endpackage

`default_nettype wire

@@ design/pcg32_dp.sv @@
// datapath: generator state, shared 32x32 multiplier, bit-serial remainder unit, result register
`default_nettype none

module pcg32_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [63:0]       cfg_data_i,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [63:0]       seed_value_i,
  input  wire logic signed [63:0] bound_i,
  input  pcg32_pkg::cmd_t        cmd_i,
  output pcg32_pkg::sts_t        sts_o,
  output logic [63:0]            random_value_o,
  output logic [63:0]            previous_seed_o
);
  import pcg32_pkg::*;

  logic [63:0] default_seed_q;
  logic [63:0] state_q, state_d;
  logic        seeded_q, seeded_d;
  logic [63:0] last_seed_q, last_seed_d;

  logic [1:0]  req_q;
  logic [63:0] seed_q;
  logic [63:0] bound_q;
  logic [63:0] prev_q;
  logic [63:0] p0_q;
  logic [31:0] p1_q;
  logic [31:0] cross_q;
  logic [31:0] hi_q;
  logic [63:0] v_q;
  logic [63:0] limit_q;
  logic [63:0] rem_q;
  logic [63:0] dvd_q;
  logic [63:0] rv_q;
  logic [63:0] ps_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] word;
  logic [63:0] rem_shift;
  logic [63:0] rem_next;

  assign word = pcg_output(state_q);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_LL: begin
        mul_a = state_q[31:0];
        mul_b = PCG_MUL[31:0];
      end
      MUL_LH: begin
        mul_a = state_q[31:0];
        mul_b = PCG_MUL[63:32];
      end
      MUL_HL: begin
        mul_a = state_q[63:32];
        mul_b = PCG_MUL[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  // one restoring step, divisor is below 2^63 so 64 bits hold the partial remainder
  assign rem_shift = {rem_q[62:0], dvd_q[63]};
  assign rem_next  = (rem_shift >= bound_q) ? rem_shift - bound_q : rem_shift;

  always_comb begin
    state_d     = state_q;
    seeded_d    = seeded_q;
    last_seed_d = last_seed_q;
    if (cmd_i.seed_user) begin
      state_d     = PCG_INC + seed_q;
      seeded_d    = 1'b1;
      last_seed_d = seed_q;
    end else if (cmd_i.seed_default) begin
      state_d  = PCG_INC + default_seed_q;
      seeded_d = 1'b1;
    end else if (cmd_i.adv) begin
      state_d = p0_q + {cross_q, 32'd0} + PCG_INC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_seed_q <= '0;
      state_q        <= '0;
      seeded_q       <= 1'b0;
      last_seed_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        default_seed_q <= cfg_data_i;
      end
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      last_seed_q <= last_seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q   <= req_type_i;
      seed_q  <= seed_value_i;
      bound_q <= bound_i;
      prev_q  <= '0;
    end
    if (cmd_i.seed_user) begin
      prev_q <= last_seed_q;
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        MUL_LL:  p0_q    <= prod;
        MUL_LH:  p1_q    <= prod[31:0];
        MUL_HL:  cross_q <= p1_q + prod[31:0];
        default: ;
      endcase
    end
    if (cmd_i.cap_hi) begin
      hi_q <= word;
    end
    if (cmd_i.cap_lo) begin
      v_q <= {hi_q, word};
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      dvd_q <= (cmd_i.div_src == DIV_SRC_LIM) ? 64'd0 - bound_q : v_q;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[62:0], 1'b0};
    end
    if (cmd_i.lim_cap) begin
      limit_q <= rem_q;
    end
    if (cmd_i.res_load) begin
      unique case (cmd_i.res_sel)
        RES_DRAW: rv_q <= v_q;
        RES_REM:  rv_q <= rem_q;
        default:  rv_q <= '0;
      endcase
      ps_q <= prev_q;
    end
  end

  assign sts_o.req_type   = req_e'(req_q);
  assign sts_o.bound_ok   = (bound_q != '0) && !bound_q[63];
  assign sts_o.seeded     = seeded_q;
  assign sts_o.v_lt_limit = v_q < limit_q;

  assign random_value_o  = rv_q;
  assign previous_seed_o = ps_q;

endmodule

`default_nettype wire

@@ design/pcg32_ctrl.sv @@
// controller: sequences seeding, generator steps, rejection loop and remainder passes
`default_nettype none

module pcg32_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  pcg32_pkg::sts_t sts_i,
  output pcg32_pkg::cmd_t cmd_o
);
  import pcg32_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b00000000001,
    ST_DECODE  = 11'b00000000010,
    ST_START   = 11'b00000000100,
    ST_MUL0    = 11'b00000001000,
    ST_MUL1    = 11'b00000010000,
    ST_MUL2    = 11'b00000100000,
    ST_ADV     = 11'b00001000000,
    ST_DIV_LIM = 11'b00010000000,
    ST_CHECK   = 11'b00100000000,
    ST_DIV_MOD = 11'b01000000000,
    ST_RESULT  = 11'b10000000000
  } state_e;

  typedef enum logic [1:0] {
    STEP_MIX = 2'd0,
    STEP_HI  = 2'd1,
    STEP_LO  = 2'd2
  } step_e;

  state_e      state_q, state_d;
  step_e       kind_q, kind_d;
  logic [3:0]  mix_cnt_q, mix_cnt_d;
  logic [5:0]  div_cnt_q, div_cnt_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    mix_cnt_d   = mix_cnt_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.req_type)
          REQ_SEED: begin
            cmd_o.seed_user = 1'b1;
            mix_cnt_d       = MIX_ROUNDS;
            kind_d          = STEP_MIX;
            state_d         = ST_MUL0;
          end
          REQ_DRAW: state_d = ST_START;
          REQ_BOUNDED: begin
            if (sts_i.bound_ok) begin
              cmd_o.div_init = 1'b1;
              cmd_o.div_src  = DIV_SRC_LIM;
              div_cnt_d      = DIV_LAST;
              state_d        = ST_DIV_LIM;
            end else begin
              state_d = ST_RESULT;
            end
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_START: begin
        cmd_o.lim_cap = 1'b1;
        if (!sts_i.seeded) begin
          cmd_o.seed_default = 1'b1;
          mix_cnt_d          = MIX_ROUNDS;
          kind_d             = STEP_MIX;
        end else begin
          kind_d = STEP_HI;
        end
        state_d = ST_MUL0;
      end
      ST_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LL;
        state_d       = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LH;
        state_d       = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HL;
        state_d       = ST_ADV;
      end
      ST_ADV: begin
        cmd_o.adv = 1'b1;
        unique case (kind_q)
          STEP_MIX: begin
            if (mix_cnt_q == 4'd1) begin
              if (sts_i.req_type == REQ_SEED) begin
                state_d = ST_RESULT;
              end else begin
                kind_d  = STEP_HI;
                state_d = ST_MUL0;
              end
            end else begin
              mix_cnt_d = mix_cnt_q - 4'd1;
              state_d   = ST_MUL0;
            end
          end
          STEP_HI: begin
            cmd_o.cap_hi = 1'b1;
            kind_d       = STEP_LO;
            state_d      = ST_MUL0;
          end
          STEP_LO: begin
            cmd_o.cap_lo = 1'b1;
            state_d      = (sts_i.req_type == REQ_DRAW) ? ST_RESULT : ST_CHECK;
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_DIV_LIM: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q - 6'd1;
        if (div_cnt_q == '0) begin
          state_d = ST_START;
        end
      end
      ST_CHECK: begin
        if (sts_i.v_lt_limit) begin
          kind_d  = STEP_HI;
          state_d = ST_MUL0;
        end else begin
          cmd_o.div_init = 1'b1;
          cmd_o.div_src  = DIV_SRC_MOD;
          div_cnt_d      = DIV_LAST;
          state_d        = ST_DIV_MOD;
        end
      end
      ST_DIV_MOD: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q - 6'd1;
        if (div_cnt_q == '0) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          unique case (sts_i.req_type)
            REQ_DRAW:    cmd_o.res_sel = RES_DRAW;
            REQ_BOUNDED: cmd_o.res_sel = sts_i.bound_ok ? RES_REM : RES_ZERO;
            default:     cmd_o.res_sel = RES_ZERO;
          endcase
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= STEP_MIX;
      mix_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      mix_cnt_q   <= mix_cnt_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ design/pcg32_stream_with_bounded_draw.sv @@
// top level of the pcg32 stream block with seeding, raw draws and bounded draws
`default_nettype none
`include "pcg32_stream_with_bounded_draw_assert.svh"

// pcg-xsh-rr generator, 64-bit state, 32-bit words. one item in, one item out.
// requests: 0 sets the seed (state = inc + seed, then ten mixing steps) and
// returns the previously set seed; 1 returns two words joined, high word first;
// 2 returns a value below bound using rejection of draws under (2^64 - n) mod n;
// a zero or negative bound answers 0 at once; code 3 answers 0 and changes nothing.
// a draw arriving before any seed request first seeds from the default_seed
// register, written on the cfg channel. the user must write it only while the
// block is idle; the block itself does not enforce this. one generator step
// runs through ST_MUL0, ST_MUL1, ST_MUL2 and ST_ADV, since the single 32x32
// multiplier is used three times (low*low, low*high, high*low) before the
// state add. a bounded draw adds two bit-serial remainder passes, one before
// and one after its draw attempts. items are handled one at a time; the next
// item is taken while the finished one still waits in the output register.
module pcg32_stream_with_bounded_draw (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write channel, default seed
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [63:0]        cfg_data_i,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [63:0]        seed_value_i,
  input  wire logic signed [63:0] bound_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [63:0]             random_value_o,
  output logic [63:0]             previous_seed_o
);
  import pcg32_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // the register write never has to wait
  assign cfg_ready_o = 1'b1;

  pcg32_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcg32_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .seed_value_i    (seed_value_i),
    .bound_i         (bound_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .random_value_o  (random_value_o),
    .previous_seed_o (previous_seed_o)
  );

  // only seed requests carry a previous seed
  `PCG32_ASSERT_NXT(a_prev_only_on_seed, cmd.res_load && (sts.req_type != REQ_SEED), previous_seed_o == '0)
  // generator never steps from an unseeded state
  `PCG32_ASSERT_IMP(a_step_after_seed, cmd.mul_en, sts.seeded)
  // an accepted item blocks the request channel until its work is done
  `PCG32_ASSERT_NXT(a_one_item_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
  // a loaded result is offered on the next cycle
  `PCG32_ASSERT_NXT(a_result_offered, cmd.res_load, out_valid_o)

endmodule

`default_nettype wire

@@ test/tb_pcg32_stream_with_bounded_draw.sv @@
// testbench for the pcg32 stream block: generator model in a scoreboard, random handshakes
`timescale 1ns / 100ps

module tb_pcg32_stream_with_bounded_draw;
  import pcg32_pkg::*;

  // lcg constants of the generator
  localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INCR = 64'd1442695040888963407;
  localparam int MIX_STEPS = 10;

  // cycles with no item moving on any channel before the run is given up
  localparam int WATCHDOG_LIMIT = 20000;
  // quiet cycles after the last result
  localparam int TAIL_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 333;

  typedef struct packed {
    logic [63:0] value;
    logic [63:0] prev_seed;
  } draw_result_t;

  // scoreboard: keeps its own copy of the generator and the expected results in order
  class draw_scoreboard;
    logic [63:0]  gen_state;
    bit           seeded;
    logic [63:0]  last_seed;
    logic [63:0]  default_seed;
    draw_result_t expected_draws[$];
    int           errors;

    function new();
      gen_state    = '0;
      seeded       = 1'b0;
      last_seed    = '0;
      default_seed = '0;
      errors       = 0;
    endfunction

    function void set_default(input logic [63:0] v);
      default_seed = v;
    endfunction

    function int pending();
      return expected_draws.size();
    endfunction

    // one xsh-rr word from the old state, then advance
    function logic [31:0] next_word();
      logic [63:0] s;
      logic [63:0] folded;
      logic [31:0] x;
      int unsigned rot;
      s         = gen_state;
      gen_state = s * LCG_MULT + LCG_INCR;
      folded    = ((s >> 18) ^ s) >> 27;
      x         = folded[31:0];
      rot       = s[63:59];
      return (x >> rot) | (x << ((32 - rot) & 31));
    endfunction

    function void reseed(input logic [63:0] seed);
      gen_state = '0;
      void'(next_word());
      gen_state = gen_state + seed;
      repeat (MIX_STEPS) void'(next_word());
      seeded = 1'b1;
    endfunction

    function logic [63:0] draw_pair();
      logic [31:0] hi;
      logic [31:0] lo;
      if (!seeded) reseed(default_seed);
      hi = next_word();
      lo = next_word();
      return {hi, lo};
    endfunction

    // rejection sampling below n; zero or negative bound answers 0 without drawing
    function logic [63:0] draw_under(input logic [63:0] n);
      logic [63:0] reject_below;
      logic [63:0] v;
      if (n == '0 || n[63]) return '0;
      reject_below = (64'd0 - n) % n;
      do begin
        v = draw_pair();
      end while (v < reject_below);
      return v % n;
    endfunction

    function void note_request(input req_e kind, input logic [63:0] seed,
                               input logic [63:0] bound);
      draw_result_t r;
      r = '0;
      case (kind)
        REQ_SEED: begin
          r.prev_seed = last_seed;
          last_seed   = seed;
          reseed(seed);
        end
        REQ_DRAW:    r.value = draw_pair();
        REQ_BOUNDED: r.value = draw_under(bound);
        default: ;
      endcase
      expected_draws.push_back(r);
    endfunction

    function void check_result(input logic [63:0] value, input logic [63:0] prev_seed);
      draw_result_t e;
      if (expected_draws.size() == 0) begin
        $error("result item with no request pending: random_value %h previous_seed %h",
               value, prev_seed);
        errors++;
        return;
      end
      e = expected_draws.pop_front();
      if (value !== e.value) begin
        $error("random_value: expected %h, actual %h", e.value, value);
        errors++;
      end
      if (prev_seed !== e.prev_seed) begin
        $error("previous_seed: expected %h, actual %h", e.prev_seed, prev_seed);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [63:0]        cfg_data_i      = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic [1:0]         req_type_i      = '0;
  logic [63:0]        seed_value_i    = '0;
  logic signed [63:0] bound_i         = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [63:0]        random_value_o;
  logic [63:0]        previous_seed_o;

  draw_scoreboard sb = new();

  // idling percentages of the current phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  bit moved;

  pcg32_stream_with_bounded_draw uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .seed_value_i    (seed_value_i),
    .bound_i         (bound_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .random_value_o  (random_value_o),
    .previous_seed_o (previous_seed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver: ready drawn fresh every cycle at the phase's stall rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor at the falling edge: inputs only change at rising edges, so every
  // handshake seen here is the one that completes at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_ready_o) begin
        sb.note_request(req_e'(req_type_i), seed_value_i, bound_i);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(random_value_o, previous_seed_o);
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_default(cfg_data_i);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("pcg32_stream_with_bounded_draw verification failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // bound mix: negatives, zero, small, near powers of two, the high-rejection
  // band from 2^62 up to 2^63, and anything positive
  function automatic logic [63:0] rand_bound();
    int pick;
    int k;
    logic [63:0] v;
    pick = $urandom_range(99);
    v    = rand64();
    if (pick < 12) begin
      v[63] = 1'b1;
    end else if (pick < 15) begin
      v = '0;
    end else if (pick < 35) begin
      v = 64'($urandom_range(1, 1000));
    end else if (pick < 50) begin
      k = $urandom_range(1, 62);
      v = (64'd1 << k) + 64'($urandom_range(0, 2)) - 64'd1;
    end else if (pick < 65) begin
      v[63:62] = 2'b01;
    end else begin
      v[63] = 1'b0;
    end
    return v;
  endfunction

  // hold one request item on the channel until it is taken
  task automatic send_request(input req_e kind, input logic [63:0] seed,
                              input logic [63:0] bound);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    seed_value_i <= seed;
    bound_i      <= bound;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
  endtask

  task automatic write_default_seed(input logic [63:0] v);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // sender off, every result in, then a quiet tail of TAIL_CYCLES on top
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // random phase; with_pause stops the sender halfway until the block is empty
  task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_pause);
    int pick;
    req_e kind;
    logic [63:0] bound;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (with_pause && i == RANDOM_PER_PHASE / 2) begin
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 12)      kind = REQ_SEED;
      else if (pick < 40) kind = REQ_DRAW;
      else if (pick < 95) kind = REQ_BOUNDED;
      else                kind = REQ_NONE;
      bound = (kind == REQ_BOUNDED) ? rand_bound() : rand64();
      send_request(kind, rand64(), bound);
    end
  endtask

  initial begin
    // reset held low at the start, released once
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default seed only counts for the first draw, so the extreme goes first
    write_default_seed(64'hFFFF_FFFF_FFFF_FFFF);

    send_idle_pct  = 12;
    recv_stall_pct = 12;
    // unused code and non-positive bounds before any seed: no automatic seeding
    send_request(REQ_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_BOUNDED, 64'h0, 64'h0);
    send_request(REQ_BOUNDED, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_BOUNDED, 64'h0, 64'h8000_0000_0000_0000);
    // first raw draw seeds from the default register
    send_request(REQ_DRAW, 64'h0, 64'h0);
    send_request(REQ_DRAW, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // seed requests hand back the previous user seed, auto seeding left it at 0
    send_request(REQ_SEED, 64'h0, 64'h0);
    send_request(REQ_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(REQ_SEED, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
    // bounded draws at the edges of the bound range
    send_request(REQ_BOUNDED, 64'h0, 64'h1);
    send_request(REQ_BOUNDED, 64'h0, 64'h2);
    send_request(REQ_BOUNDED, 64'h0, 64'h3);
    send_request(REQ_BOUNDED, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(REQ_BOUNDED, 64'h0, 64'h4000_0000_0000_0001);
    send_request(REQ_BOUNDED, 64'h0, 64'h5555_5555_5555_5555);
    send_request(REQ_BOUNDED, 64'h0, 64'h2AAA_AAAA_AAAA_AAAB);
    send_request(REQ_BOUNDED, 64'hFFFF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000);
    // fields that the request does not use carry junk
    send_request(REQ_DRAW, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
    send_request(REQ_NONE, 64'h5A5A_5A5A_5A5A_5A5A, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(REQ_SEED, rand64(), rand64());
    send_request(REQ_SEED, 64'h0, 64'h8000_0000_0000_0000);
    send_request(REQ_BOUNDED, 64'h0, 64'd1000);

    wait_drained();
    write_default_seed(64'h0);
    run_phase(0, 0, 1'b1);

    wait_drained();
    write_default_seed(rand64());
    run_phase(78, 0, 1'b0);

    wait_drained();
    write_default_seed(64'h8000_0000_0000_0000);
    run_phase(0, 78, 1'b1);

    wait_drained();
    write_default_seed(rand64());
    run_phase(12, 12, 1'b0);

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pcg32_stream_with_bounded_draw verification clean");
    end else begin
      $display("pcg32_stream_with_bounded_draw verification failed");
    end
    $finish;
  end

endmodule
